FILE: rtl/frame_history_concealment_ring_unit_assert.svh
// Assertion macros shared by the frame history ring RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef FRAME_HISTORY_CONCEALMENT_RING_UNIT_ASSERT_SVH
`define FRAME_HISTORY_CONCEALMENT_RING_UNIT_ASSERT_SVH

// same-cycle implication
`define FHCR_ASSERT_HOLD(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FHCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fhcr_pkg.sv
// Package for the frame history concealment ring: opcodes, field widths,
// control bundle type and the duration clamp. No dependencies.
`default_nettype none

package fhcr_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int HANDLE_W  = 32;
    localparam int PTS_W     = 48;
    localparam int DUR_W     = 32;
    localparam int LEN_W     = 31;
    localparam int OP_W      = 2;

    typedef enum logic [OP_W-1:0] {
        OP_RECV  = 2'd0,
        OP_FILL  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

    function automatic logic [LEN_W-1:0] clamp_dur(input logic signed [DUR_W-1:0] d);
        logic [LEN_W-1:0] r;
        r = d[DUR_W-1] ? '0 : d[LEN_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fhcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module fhcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fhcr_ctrl.sv
// Ring pointers, fill count, concealment state and result strobes.
// Depends on fhcr_pkg and the shared assertion macro header.
`default_nettype none
`include "frame_history_concealment_ring_unit_assert.svh"

module fhcr_ctrl #(
    parameter int DEPTH = fhcr_pkg::DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 accept,
    input  wire logic [fhcr_pkg::OP_W-1:0]            opcode,
    input  wire logic signed [fhcr_pkg::DUR_W-1:0]    duration_us,
    output fhcr_pkg::ram_ctl_t                        ram_ctl,
    output logic [PTR_W-1:0]                          wr_addr,
    output logic [PTR_W-1:0]                          rd_addr,
    output logic                                      done,
    output logic                                      frame_valid,
    output logic [CNT_W-1:0]                          fill_count,
    output logic [fhcr_pkg::LEN_W-1:0]                newest_duration_us
);

    import fhcr_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL      = CNT_W'(DEPTH);

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] play_reg, play_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             conceal_reg, conceal_next;
    logic [LEN_W-1:0] newest_reg, newest_next;
    logic             done_reg, done_next;
    logic             valid_reg, valid_next;

    logic [PTR_W-1:0] newest_slot;
    logic [PTR_W-1:0] cur_slot;
    logic [PTR_W-1:0] oldest_slot;
    logic [CNT_W:0]   oldest_diff;
    op_t              op;

    always_comb
    begin
        op          = op_t'(opcode);
        newest_slot = (wp_reg == '0) ? LAST_SLOT : wp_reg - 1'b1;
        cur_slot    = conceal_reg ? play_reg : newest_slot;
        oldest_diff = (CNT_W + 1)'(wp_reg) - {1'b0, held_reg};
        if (oldest_diff[CNT_W])
        begin
            oldest_diff = oldest_diff + (CNT_W + 1)'(DEPTH);
        end
        oldest_slot = oldest_diff[PTR_W-1:0];

        wp_next      = wp_reg;
        play_next    = play_reg;
        held_next    = held_reg;
        conceal_next = conceal_reg;
        newest_next  = newest_reg;
        valid_next   = 1'b0;
        done_next    = accept;
        ram_ctl      = '0;
        wr_addr      = wp_reg;
        rd_addr      = cur_slot;

        if (accept)
        begin
            case (op)
                OP_RECV:
                begin
                    ram_ctl.wr_en = 1'b1;
                    wp_next       = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
                    held_next     = (held_reg == FULL) ? held_reg : held_reg + 1'b1;
                    conceal_next  = 1'b0;
                    play_next     = wp_reg;
                    newest_next   = clamp_dur(duration_us);
                end
                OP_FILL:
                begin
                    if (held_reg != '0)
                    begin
                        ram_ctl.rd_en = 1'b1;
                        valid_next    = 1'b1;
                        conceal_next  = 1'b1;
                        if (cur_slot != oldest_slot)
                        begin
                            play_next = (cur_slot == '0) ? LAST_SLOT : cur_slot - 1'b1;
                        end
                        else
                        begin
                            play_next = cur_slot;
                        end
                    end
                end
                OP_CLEAR:
                begin
                    wp_next      = '0;
                    play_next    = '0;
                    held_next    = '0;
                    conceal_next = 1'b0;
                    newest_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            play_reg    <= '0;
            held_reg    <= '0;
            conceal_reg <= 1'b0;
            newest_reg  <= '0;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            play_reg    <= play_next;
            held_reg    <= held_next;
            conceal_reg <= conceal_next;
            newest_reg  <= newest_next;
            done_reg    <= done_next;
            valid_reg   <= valid_next;
        end
    end

    assign done               = done_reg;
    assign frame_valid        = valid_reg;
    assign fill_count         = held_reg;
    assign newest_duration_us = newest_reg;

    `FHCR_ASSERT_HOLD(a_held_bound, 1'b1, held_reg <= FULL, "fill count above depth")
    `FHCR_ASSERT_NEXT(a_beat_done, accept, done_reg, "accepted beat gave no result")
    `FHCR_ASSERT_NEXT(a_no_spurious, !accept, !done_reg, "result without accepted beat")
    `FHCR_ASSERT_HOLD(a_valid_count, valid_reg, done_reg && held_reg != '0,
                      "replay reported with empty history")
    `FHCR_ASSERT_HOLD(a_play_range, conceal_reg, play_reg <= LAST_SLOT,
                      "play pointer out of range")

endmodule

`default_nettype wire

FILE: rtl/frame_history_concealment_ring_unit.sv
// Top level of the frame history concealment ring.
// Depends on fhcr_pkg, fhcr_ctrl, fhcr_ram.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start, busy        | opcode, frame_handle, pts_us, duration_us
//  result   | done (one cycle)   | frame_valid, out_handle, out_pts_us,
//           |                    | out_duration_us, fill_count, newest_duration_us
//
// One beat per cycle is accepted; busy stays low.
// The result for a beat shows in the cycle after acceptance, as done and
// frame_valid are registered and the RAM's read port is registered.
// Reset clears pointers, count and concealment state; slot storage is not
// cleared and needs no clearing pass.
// The receiver cannot stall; done is high for exactly one cycle per beat.
`default_nettype none

module frame_history_concealment_ring_unit #(
    parameter int DEPTH = fhcr_pkg::DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [fhcr_pkg::OP_W-1:0]             opcode,
    input  wire logic [fhcr_pkg::HANDLE_W-1:0]         frame_handle,
    input  wire logic signed [fhcr_pkg::PTS_W-1:0]     pts_us,
    input  wire logic signed [fhcr_pkg::DUR_W-1:0]     duration_us,
    output logic                                       done,
    output logic                                       frame_valid,
    output logic [fhcr_pkg::HANDLE_W-1:0]              out_handle,
    output logic signed [fhcr_pkg::PTS_W-1:0]          out_pts_us,
    output logic [fhcr_pkg::LEN_W-1:0]                 out_duration_us,
    output logic [CNT_W-1:0]                           fill_count,
    output logic [fhcr_pkg::LEN_W-1:0]                 newest_duration_us
);

    import fhcr_pkg::*;

    localparam int SLOT_W = HANDLE_W + PTS_W + LEN_W;

    logic             accept;
    ram_ctl_t         ram_ctl;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign wr_slot = {frame_handle, pts_us, clamp_dur(duration_us)};

    fhcr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .opcode             (opcode),
        .duration_us        (duration_us),
        .ram_ctl            (ram_ctl),
        .wr_addr            (wr_addr),
        .rd_addr            (rd_addr),
        .done               (done),
        .frame_valid        (frame_valid),
        .fill_count         (fill_count),
        .newest_duration_us (newest_duration_us)
    );

    fhcr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_ctl.wr_en),
        .waddr (wr_addr),
        .wdata (wr_slot),
        .re    (ram_ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rd_slot)
    );

    assign out_handle      = frame_valid ? rd_slot[SLOT_W-1 -: HANDLE_W] : '0;
    assign out_pts_us      = frame_valid ? rd_slot[LEN_W +: PTS_W] : '0;
    assign out_duration_us = frame_valid ? rd_slot[LEN_W-1:0] : '0;

endmodule

`default_nettype wire
